// ----- hdl/clh_pkg.sv -----
`timescale 1ns / 1ps
// clh_pkg: constants, types and helpers shared by the channel luma histogram.
// No dependencies.
package clh_pkg;

    localparam int BIN_COUNT  = 256;
    localparam int COUNT_BITS = 24;
    localparam int OUT_BITS   = 24;
    localparam int CHANNELS   = 4;
    localparam int BIN_BITS   = $clog2(BIN_COUNT);
    localparam int CH_BITS    = $clog2(CHANNELS);
    localparam int ADDR_BITS  = CH_BITS + BIN_BITS;
    localparam int RAM_DEPTH  = CHANNELS << BIN_BITS;

    // Q16 luminosity weights
    localparam logic [15:0] W_RED   = 16'd13926;
    localparam logic [15:0] W_GREEN = 16'd46885;
    localparam logic [15:0] W_BLUE  = 16'd4725;

    localparam logic [COUNT_BITS-1:0] COUNT_LIMIT = {COUNT_BITS{1'b1}};

    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [ADDR_BITS-1:0]  addr_t;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_COUNT  = 2'd1,
        CMD_READ   = 2'd2,
        CMD_UNUSED = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_COUNT,
        ST_READ,
        ST_DONE
    } state_t;

    // channel value 0..255 to bin: (v * BIN_COUNT) >> 8
    function automatic logic [BIN_BITS-1:0] bin_of(input logic [7:0] v);
        logic [16:0] prod;
        prod = {9'd0, v} * 17'(BIN_COUNT);
        return BIN_BITS'(prod[16:8]);
    endfunction

    // counts leave the block on 24 bits
    function automatic logic [OUT_BITS-1:0] to_out(input count_t c);
        logic [COUNT_BITS+OUT_BITS-1:0] ext;
        ext = {{OUT_BITS{1'b0}}, c};
        return ext[OUT_BITS-1:0];
    endfunction

endpackage

// ----- hdl/clh_ram.sv -----
`timescale 1ns / 1ps
// clh_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module clh_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- hdl/channel_luma_histogram_top.sv -----
`timescale 1ns / 1ps
// channel_luma_histogram_top: four 256-bin histograms (red, green, blue, gray) in one RAM.
// Depends on clh_pkg and clh_ram.

// One word in, one word out. All 1024 bins share one RAM with a single read and a
// single write port, so a count word does its four read-modify-write bumps back to
// back, then hands its result off; s_ready is high only while idle, so no new word
// is taken before then. Clear sweeps the RAM one bin a cycle; the same pass runs
// after reset, with s_ready low. The result register lets the next word in while a
// result waits on m_ready.
module channel_luma_histogram_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_command,
    input  logic [31:0] s_pixel_word,
    input  logic [1:0]  s_read_channel,
    input  logic [7:0]  s_read_index,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [23:0] m_bin_count,
    output logic [23:0] m_max_count
);

    clh_pkg::state_t state_reg, state_next;
    logic [2:0]      step_reg, step_next;
    clh_pkg::addr_t  clr_addr_reg, clr_addr_next;
    clh_pkg::addr_t  prev_addr_reg, prev_addr_next;
    logic            clear_resp_reg, clear_resp_next;
    logic            read_hit_reg, read_hit_next;
    clh_pkg::count_t max_reg, max_next;
    clh_pkg::count_t bin_res_reg, bin_res_next;
    logic            m_valid_reg, m_valid_next;
    logic [clh_pkg::OUT_BITS-1:0] m_bin_reg, m_bin_next;
    logic [clh_pkg::OUT_BITS-1:0] m_max_reg, m_max_next;

    // captured word
    logic [7:0]  r_reg, g_reg, b_reg;
    logic [23:0] pr_reg, pg_reg, pb_reg;
    logic [1:0]  rd_chan_reg;
    logic [7:0]  rd_idx_reg;

    logic            accept;
    clh_pkg::cmd_t   cmd;
    logic [23:0]     luma_sum;
    logic [7:0]      gray;
    logic [7:0]      chan_val;
    logic            ram_we, ram_re;
    clh_pkg::addr_t  ram_waddr, ram_raddr;
    clh_pkg::count_t ram_wdata, ram_rdata, bumped;
    logic            out_free;

    assign s_ready  = (state_reg == clh_pkg::ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign cmd      = clh_pkg::cmd_t'(s_command);
    assign luma_sum = pr_reg + pg_reg + pb_reg;
    assign gray     = luma_sum[23:16];
    assign bumped   = (ram_rdata < clh_pkg::COUNT_LIMIT) ? ram_rdata + 1'b1 : ram_rdata;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        unique case (step_reg[1:0])
            2'd0:    chan_val = r_reg;
            2'd1:    chan_val = g_reg;
            2'd2:    chan_val = b_reg;
            default: chan_val = gray;
        endcase
    end

    clh_ram #(
        .WIDTH(clh_pkg::COUNT_BITS),
        .DEPTH(clh_pkg::RAM_DEPTH)
    ) u_bins (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            clh_pkg::ST_CLEAR: begin
                if (clr_addr_reg == clh_pkg::addr_t'(clh_pkg::RAM_DEPTH - 1)) begin
                    state_next = clear_resp_reg ? clh_pkg::ST_DONE : clh_pkg::ST_IDLE;
                end
            end
            clh_pkg::ST_IDLE: begin
                if (accept) begin
                    unique case (cmd)
                        clh_pkg::CMD_CLEAR:  state_next = clh_pkg::ST_CLEAR;
                        clh_pkg::CMD_COUNT:  state_next = clh_pkg::ST_COUNT;
                        clh_pkg::CMD_READ:   state_next = clh_pkg::ST_READ;
                        clh_pkg::CMD_UNUSED: state_next = clh_pkg::ST_DONE;
                    endcase
                end
            end
            clh_pkg::ST_COUNT: begin
                if (step_reg == 3'd4) begin
                    state_next = clh_pkg::ST_DONE;
                end
            end
            clh_pkg::ST_READ: begin
                if (step_reg == 3'd1) begin
                    state_next = clh_pkg::ST_DONE;
                end
            end
            clh_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = clh_pkg::ST_IDLE;
                end
            end
            default: state_next = clh_pkg::ST_IDLE;
        endcase
    end

    // datapath and RAM control
    always_comb begin
        step_next       = step_reg;
        clr_addr_next   = clr_addr_reg;
        prev_addr_next  = prev_addr_reg;
        clear_resp_next = clear_resp_reg;
        read_hit_next   = read_hit_reg;
        max_next        = max_reg;
        bin_res_next    = bin_res_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_bin_next      = m_bin_reg;
        m_max_next      = m_max_reg;
        ram_we          = 1'b0;
        ram_waddr       = prev_addr_reg;
        ram_wdata       = bumped;
        ram_re          = 1'b0;
        ram_raddr       = {step_reg[1:0], clh_pkg::bin_of(chan_val)};
        unique case (state_reg)
            clh_pkg::ST_CLEAR: begin
                ram_we        = 1'b1;
                ram_waddr     = clr_addr_reg;
                ram_wdata     = '0;
                clr_addr_next = clr_addr_reg + 1'b1;
            end
            clh_pkg::ST_IDLE: begin
                step_next    = '0;
                bin_res_next = '0;
                if (accept && cmd == clh_pkg::CMD_CLEAR) begin
                    clear_resp_next = 1'b1;
                    clr_addr_next   = '0;
                    max_next        = '0;
                end
            end
            clh_pkg::ST_COUNT: begin
                step_next      = step_reg + 1'b1;
                ram_re         = (step_reg != 3'd4);
                prev_addr_next = ram_raddr;
                // bins of one word sit in different channels: no same-entry overlap
                if (step_reg != 3'd0) begin
                    ram_we = 1'b1;
                    if (bumped > max_reg) begin
                        max_next = bumped;
                    end
                end
            end
            clh_pkg::ST_READ: begin
                step_next = step_reg + 1'b1;
                if (step_reg == 3'd0) begin
                    ram_re    = read_hit_reg;
                    ram_raddr = {rd_chan_reg, rd_idx_reg[clh_pkg::BIN_BITS-1:0]};
                end else begin
                    bin_res_next = read_hit_reg ? ram_rdata : '0;
                end
            end
            clh_pkg::ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_bin_next   = clh_pkg::to_out(bin_res_reg);
                    m_max_next   = clh_pkg::to_out(max_reg);
                end
            end
            default: ;
        endcase
        if (accept) begin
            read_hit_next = ({1'b0, s_read_index} < 9'(clh_pkg::BIN_COUNT));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= clh_pkg::ST_CLEAR;
            step_reg       <= '0;
            clr_addr_reg   <= '0;
            clear_resp_reg <= 1'b0;
            max_reg        <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            step_reg       <= step_next;
            clr_addr_reg   <= clr_addr_next;
            clear_resp_reg <= clear_resp_next;
            max_reg        <= max_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        prev_addr_reg <= prev_addr_next;
        read_hit_reg  <= read_hit_next;
        bin_res_reg   <= bin_res_next;
        m_bin_reg     <= m_bin_next;
        m_max_reg     <= m_max_next;
        if (accept) begin
            r_reg       <= s_pixel_word[23:16];
            g_reg       <= s_pixel_word[15:8];
            b_reg       <= s_pixel_word[7:0];
            // weighted terms on 24 bits; the three always sum below 2^24
            pr_reg      <= {16'd0, s_pixel_word[23:16]} * {8'd0, clh_pkg::W_RED};
            pg_reg      <= {16'd0, s_pixel_word[15:8]} * {8'd0, clh_pkg::W_GREEN};
            pb_reg      <= {16'd0, s_pixel_word[7:0]} * {8'd0, clh_pkg::W_BLUE};
            rd_chan_reg <= s_read_channel;
            rd_idx_reg  <= s_read_index;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_bin_count = m_bin_reg;
    assign m_max_count = m_max_reg;

    // no RAM traffic while waiting for a word
    a_idle_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == clh_pkg::ST_IDLE) |-> (!ram_we && !ram_re))
        else $error("RAM access while idle");

    // a bump never writes the entry being read in the same cycle
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == clh_pkg::ST_COUNT && ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("read-modify-write overlap on one bin");

    // the maximum only drops on a clear word
    a_max_mono: assert property (@(posedge aclk) disable iff (!aresetn)
        !(accept && cmd == clh_pkg::CMD_CLEAR) |=> (max_reg >= $past(max_reg)))
        else $error("maximum decreased without clear");

endmodule

// ----- sim/channel_luma_histogram_top_test.sv -----
`timescale 1ns / 1ps
// channel_luma_histogram_top_test: self-checking bench for the four-way pixel histogram.
// Keeps its own copy of the bins, predicts each result word and checks it on the m_ side.
// Depends on clh_pkg and channel_luma_histogram_top.
module channel_luma_histogram_top_test;
    import clh_pkg::*;

    localparam int CYCLE_LIMIT = 500000;

    typedef struct {
        logic [23:0] bin_count;
        logic [23:0] max_count;
    } hist_result_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_command;
    logic [31:0] s_pixel_word;
    logic [1:0]  s_read_channel;
    logic [7:0]  s_read_index;
    logic        m_valid;
    logic        m_ready;
    logic [23:0] m_bin_count;
    logic [23:0] m_max_count;

    // bench copy of the histogram state
    count_t       model_bins [CHANNELS][BIN_COUNT];
    count_t       model_peak;
    hist_result_t pending_results [$];

    int          send_idle_pct;
    int          recv_idle_pct;
    int          stall_left;
    int          fail_count;
    int          cycle_count;
    logic [31:0] palette [8];

    channel_luma_histogram_top dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_pixel_word   (s_pixel_word),
        .s_read_channel (s_read_channel),
        .s_read_index   (s_read_index),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_bin_count    (m_bin_count),
        .m_max_count    (m_max_count)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Some tests failed");
        $finish;
    end

    // receiver: random idling, or a counted hold-off when stall_left is set
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_ready = 1'b0;
            stall_left--;
        end else begin
            m_ready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // compare each accepted result word with the oldest prediction
    always @(posedge aclk) begin
        hist_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result word: bin_count %0d max_count %0d",
                       m_bin_count, m_max_count);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_bin_count !== want.bin_count) begin
                    $error("bin_count: expected %0d, actual %0d", want.bin_count, m_bin_count);
                    fail_count++;
                end
                if (m_max_count !== want.max_count) begin
                    $error("max_count: expected %0d, actual %0d", want.max_count, m_max_count);
                    fail_count++;
                end
            end
        end
    end

    function automatic void clear_model();
        for (int c = 0; c < CHANNELS; c++)
            for (int b = 0; b < BIN_COUNT; b++)
                model_bins[c][b] = '0;
        model_peak = '0;
    endfunction

    function automatic void bump_bin(int ch, logic [7:0] v);
        int unsigned b;
        count_t      c;
        b = (int'(v) * BIN_COUNT) >> 8;
        if (b >= BIN_COUNT)
            b = BIN_COUNT - 1;
        c = model_bins[ch][b];
        if (c != COUNT_LIMIT)
            c = c + 1'b1;
        model_bins[ch][b] = c;
        if (c > model_peak)
            model_peak = c;
    endfunction

    function automatic void predict_histogram_word(cmd_t cmd, logic [31:0] pix,
                                                   logic [1:0] ch, logic [7:0] idx);
        hist_result_t res;
        int unsigned  r, g, b, gray;
        count_t       reading;
        reading = '0;
        case (cmd)
            CMD_CLEAR: begin
                clear_model();
            end
            CMD_COUNT: begin
                r = pix[23:16];
                g = pix[15:8];
                b = pix[7:0];
                gray = (int'(W_RED) * r + int'(W_GREEN) * g + int'(W_BLUE) * b) >> 16;
                bump_bin(0, r[7:0]);
                bump_bin(1, g[7:0]);
                bump_bin(2, b[7:0]);
                bump_bin(3, gray[7:0]);
            end
            CMD_READ: begin
                if (idx < BIN_COUNT)
                    reading = model_bins[ch][idx];
            end
            default: begin
            end
        endcase
        res.bin_count = 24'(reading);
        res.max_count = 24'(model_peak);
        pending_results.push_back(res);
    endfunction

    // offer one word and wait for acceptance; valid is left high for the next call
    task automatic send_word(cmd_t cmd, logic [31:0] pix, logic [1:0] ch, logic [7:0] idx);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_command      = cmd;
        s_pixel_word   = pix;
        s_read_channel = ch;
        s_read_index   = idx;
        s_valid        = 1'b1;
        do
            @(posedge aclk);
        while (!s_ready);
        predict_histogram_word(cmd, pix, ch, idx);
    endtask

    task automatic wait_results_drained();
        @(negedge aclk);
        s_valid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
    endtask

    task automatic test_reset_state();
        send_word(CMD_READ, 32'h0, 2'd0, 8'd0);
        send_word(CMD_READ, 32'h0, 2'd3, 8'd255);
        send_word(CMD_UNUSED, 32'hFFFF_FFFF, 2'd3, 8'hFF);
        wait_results_drained();
    endtask

    task automatic test_directed();
        send_word(CMD_COUNT, 32'h0000_0000, 2'd0, 8'd0);
        send_word(CMD_COUNT, 32'hFFFF_FFFF, 2'd3, 8'hFF);
        send_word(CMD_COUNT, 32'hFF00_0000, 2'd0, 8'd0);   // alpha only
        send_word(CMD_COUNT, 32'h00FF_0000, 2'd0, 8'd0);
        send_word(CMD_COUNT, 32'h0000_FF00, 2'd0, 8'd0);
        send_word(CMD_COUNT, 32'h0000_00FF, 2'd0, 8'd0);
        send_word(CMD_COUNT, 32'h8080_8080, 2'd0, 8'd0);
        send_word(CMD_COUNT, 32'h0000_0000, 2'd0, 8'd0);
        for (int c = 0; c < CHANNELS; c++) begin
            send_word(CMD_READ, 32'h0, c[1:0], 8'd0);
            send_word(CMD_READ, 32'h0, c[1:0], 8'd255);
        end
        send_word(CMD_READ, 32'h0, 2'd3, 8'd128);
        send_word(CMD_UNUSED, 32'h5A5A_A5A5, 2'd1, 8'd77);
        send_word(CMD_CLEAR, 32'hFFFF_FFFF, 2'd3, 8'hFF);
        send_word(CMD_READ, 32'h0, 2'd0, 8'd0);
        send_word(CMD_READ, 32'h0, 2'd3, 8'd255);
        send_word(CMD_COUNT, 32'h0012_3456, 2'd0, 8'd0);
        send_word(CMD_READ, 32'h0, 2'd1, 8'h34);
        wait_results_drained();
    endtask

    task automatic test_random(int n, int send_pct, int recv_pct);
        int          pick;
        int          slot;
        logic [31:0] pix;
        logic [7:0]  idx;
        cmd_t        cmd;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        // small palette so bins climb and the maximum moves
        for (int i = 0; i < 8; i++)
            palette[i] = $urandom;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(99);
            slot = $urandom_range(7);
            if (pick < 2)
                cmd = CMD_CLEAR;
            else if (pick < 62)
                cmd = CMD_COUNT;
            else if (pick < 94)
                cmd = CMD_READ;
            else
                cmd = CMD_UNUSED;
            pix = ($urandom_range(1) != 0) ? palette[slot] : $urandom;
            if ($urandom_range(1) != 0)
                idx = $urandom_range(255);
            else
                idx = palette[slot][8 * $urandom_range(2) +: 8];
            send_word(cmd, pix, 2'($urandom_range(3)), idx);
            if ($urandom_range(99) < 2)
                wait_results_drained();
        end
        wait_results_drained();
    endtask

    // hold the m_ side off long enough that the block backs up onto s_ready
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        @(negedge aclk);
        stall_left = 400;
        for (int i = 0; i < 30; i++)
            send_word(CMD_COUNT, (i % 3 == 0) ? 32'h00C0_FFEE : $urandom, 2'd0, 8'd0);
        send_word(CMD_READ, 32'h0, 2'd0, 8'hC0);
        wait_results_drained();
    endtask

    initial begin
        aclk           = 1'b0;
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_command      = CMD_UNUSED;
        s_pixel_word   = '0;
        s_read_channel = '0;
        s_read_index   = '0;
        m_ready        = 1'b0;
        send_idle_pct  = 0;
        recv_idle_pct  = 0;
        stall_left     = 0;
        fail_count     = 0;
        clear_model();
        repeat (8) @(negedge aclk);
        aresetn = 1'b1;

        test_reset_state();
        test_directed();
        test_random(160, 23, 88);
        test_random(160, 88, 23);
        test_random(160, 0, 0);
        test_backpressure();

        wait_results_drained();
        repeat (50) @(posedge aclk);
        if (pending_results.size() != 0) begin
            $error("%0d result words never arrived", pending_results.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/clh_pkg.sv
hdl/clh_ram.sv
hdl/channel_luma_histogram_top.sv
sim/channel_luma_histogram_top_test.sv
